[rtl/core/text_console_char_writer_top_defines.svh]
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Invariant that holds at every clock edge out of reset.
`define TCW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

[rtl/core/tcw_pkg.sv]
// Constants, codes and helpers of the text console writer.
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // Derived internal widths
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = $clog2(COLUMNS);

  // Port field widths
  localparam int FUNC_W       = 2;
  localparam int CHAR_W       = 8;
  localparam int COLOR_W      = 8;
  localparam int CELL_W       = CHAR_W + COLOR_W;
  localparam int CELL_INDEX_W = 11;
  localparam int CURSOR_W     = 11;
  localparam int CUR_ROW_W    = 5;
  localparam int CUR_COL_W    = 7;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Character and color constants
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd10;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0]  ch,
                                                  input logic [COLOR_W-1:0] color);
    return {color, ch};
  endfunction

endpackage

`default_nettype wire

[rtl/core/text_console_char_writer_top.sv]
// Top level of the text console writer: position control and frame store sweeps.
//
//  channel  | signals                                          | handshake
//  ---------+--------------------------------------------------+---------------------------
//  command  | func_i, char_code_i, cell_index_i                | taken when start & !busy
//  result   | cursor_location_o, cell_entry_o, cur_row_o,      | one-cycle done_o strobe
//           | cur_column_o                                     |
//  config   | cfg_text_color_i                                 | cfg_valid_i & cfg_ready_o
//
// Put, newline, unused code, out-of-range read: done_o in the next cycle, a new command each
// cycle unless a line end or newline on the last row starts a scroll. Read: data comes through
// the registered read port of the frame store. Clear: one cell written per cycle through the
// single write port. Scroll: copy pipeline of read then write, then blank last line.
// After reset the frame store is blanked with busy high; config waits while busy. The
// receiver cannot stall; done_o marks each result for one cycle.
`default_nettype none
`include "text_console_char_writer_top_defines.svh"

module text_console_char_writer_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [tcw_pkg::FUNC_W-1:0]        func_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]        char_code_i,
  input  wire logic [tcw_pkg::CELL_INDEX_W-1:0]  cell_index_i,
  output logic                                   done_o,
  output logic      [tcw_pkg::CURSOR_W-1:0]      cursor_location_o,
  output logic      [tcw_pkg::CELL_W-1:0]        cell_entry_o,
  output logic      [tcw_pkg::CUR_ROW_W-1:0]     cur_row_o,
  output logic      [tcw_pkg::CUR_COL_W-1:0]     cur_column_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [tcw_pkg::COLOR_W-1:0]       cfg_text_color_i
);

  localparam int AW       = tcw_pkg::ADDR_W;
  localparam int CW       = tcw_pkg::CNT_W;
  localparam int RW       = tcw_pkg::ROW_W;
  localparam int LW       = tcw_pkg::COL_W;
  localparam int DW       = tcw_pkg::CELL_W;
  localparam int CURW     = tcw_pkg::CURSOR_W;
  localparam int ROWPW    = tcw_pkg::CUR_ROW_W;
  localparam int COLPW    = tcw_pkg::CUR_COL_W;
  localparam int COL_LAST = tcw_pkg::COLUMNS - 1;
  localparam int ROW_LAST = tcw_pkg::ROWS - 1;
  localparam int LAST_LINE = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_SCROLL = 2'd2;
  localparam logic [1:0] S_FILL   = 2'd3;

  logic [1:0]                      state_q, state_d;
  logic [RW-1:0]                   row_q, row_d;
  logic [LW-1:0]                   col_q, col_d;
  logic [CW-1:0]                   cursor_q, cursor_d;
  logic [tcw_pkg::COLOR_W-1:0]     color_q;
  logic                            done_q, done_d;
  logic [DW-1:0]                   entry_q, entry_d;
  logic [CW-1:0]                   src_q, src_d;
  logic                            pend_q, pend_d;
  logic [AW-1:0]                   pend_addr_q, pend_addr_d;
  logic [AW-1:0]                   fill_addr_q, fill_addr_d;
  logic [DW-1:0]                   fill_val_q, fill_val_d;
  logic                            fill_report_q, fill_report_d;

  logic                            accept;
  logic                            col_last, row_last;
  logic [CW-1:0]                   put_addr;
  logic                            ram_we, ram_re;
  logic [AW-1:0]                   ram_waddr, ram_raddr;
  logic [DW-1:0]                   ram_wdata, ram_rdata;

  tcw_ram #(
    .WIDTH(DW),
    .DEPTH(tcw_pkg::CELL_COUNT)
  ) u_frame_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign accept   = start && (state_q == S_IDLE);
  assign col_last = (col_q == LW'(COL_LAST));
  assign row_last = (row_q == RW'(ROW_LAST));
  assign put_addr = CW'(CW'(row_q) * CW'(tcw_pkg::COLUMNS) + CW'(col_q));

  always_comb begin
    state_d       = state_q;
    row_d         = row_q;
    col_d         = col_q;
    cursor_d      = cursor_q;
    done_d        = 1'b0;
    entry_d       = entry_q;
    src_d         = src_q;
    pend_d        = 1'b0;
    pend_addr_d   = pend_addr_q;
    fill_addr_d   = fill_addr_q;
    fill_val_d    = fill_val_q;
    fill_report_d = fill_report_q;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          entry_d = '0;
          case (func_i)
            tcw_pkg::FUNC_PUT: begin
              if (char_code_i != tcw_pkg::NEWLINE_CODE) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(put_addr);
                ram_wdata = tcw_pkg::make_cell(char_code_i, color_q);
                cursor_d  = put_addr + CW'(1);
              end
              if (char_code_i != tcw_pkg::NEWLINE_CODE && !col_last) begin
                col_d  = col_q + LW'(1);
                done_d = 1'b1;
              end else begin
                // Line end or newline: next line, scroll past the bottom
                col_d = '0;
                if (row_last) begin
                  src_d   = CW'(tcw_pkg::COLUMNS);
                  state_d = S_SCROLL;
                end else begin
                  row_d  = row_q + RW'(1);
                  done_d = 1'b1;
                end
              end
            end
            tcw_pkg::FUNC_CLEAR: begin
              row_d         = '0;
              col_d         = '0;
              fill_addr_d   = '0;
              fill_val_d    = tcw_pkg::make_cell(tcw_pkg::SPACE_CODE, color_q);
              fill_report_d = 1'b1;
              state_d       = S_FILL;
            end
            tcw_pkg::FUNC_READ: begin
              if (int'(cell_index_i) < tcw_pkg::CELL_COUNT) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(cell_index_i);
                state_d   = S_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        entry_d = ram_rdata;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_SCROLL: begin
        // Read one line ahead, write the beat back in the next cycle
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q;
          ram_wdata = ram_rdata;
        end
        if (src_q != CW'(tcw_pkg::CELL_COUNT)) begin
          ram_re      = 1'b1;
          ram_raddr   = AW'(src_q);
          src_d       = src_q + CW'(1);
          pend_d      = 1'b1;
          pend_addr_d = AW'(src_q - CW'(tcw_pkg::COLUMNS));
        end else begin
          fill_addr_d   = AW'(LAST_LINE);
          fill_val_d    = tcw_pkg::make_cell(tcw_pkg::SPACE_CODE, color_q);
          fill_report_d = 1'b1;
          state_d       = S_FILL;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_addr_q;
        ram_wdata = fill_val_q;
        if (fill_addr_q == AW'(tcw_pkg::CELL_COUNT - 1)) begin
          done_d  = fill_report_q;
          state_d = S_IDLE;
        end else begin
          fill_addr_d = fill_addr_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Blank the frame store after reset, without a result strobe
      state_q       <= S_FILL;
      row_q         <= '0;
      col_q         <= '0;
      cursor_q      <= '0;
      color_q       <= tcw_pkg::RESET_COLOR;
      done_q        <= 1'b0;
      entry_q       <= '0;
      src_q         <= '0;
      pend_q        <= 1'b0;
      pend_addr_q   <= '0;
      fill_addr_q   <= '0;
      fill_val_q    <= tcw_pkg::make_cell(tcw_pkg::SPACE_CODE, tcw_pkg::RESET_COLOR);
      fill_report_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      row_q         <= row_d;
      col_q         <= col_d;
      cursor_q      <= cursor_d;
      done_q        <= done_d;
      entry_q       <= entry_d;
      src_q         <= src_d;
      pend_q        <= pend_d;
      pend_addr_q   <= pend_addr_d;
      fill_addr_q   <= fill_addr_d;
      fill_val_q    <= fill_val_d;
      fill_report_q <= fill_report_d;
      if (cfg_valid_i && cfg_ready_o) begin
        color_q <= cfg_text_color_i;
      end
    end
  end

  assign busy              = (state_q != S_IDLE);
  assign cfg_ready_o       = !busy;
  assign done_o            = done_q;
  assign cursor_location_o = CURW'(cursor_q);
  assign cell_entry_o      = entry_q;
  assign cur_row_o         = ROWPW'(row_q);
  assign cur_column_o      = COLPW'(col_q);

  `TCW_ASSERT_NEXT(a_put_done, accept && func_i == tcw_pkg::FUNC_PUT && char_code_i != tcw_pkg::NEWLINE_CODE && !(col_last && row_last), done_q, "plain put did not finish in one cycle")
  `TCW_ASSERT_IMPL(a_no_write_in_read, state_q == S_READ, !ram_we, "frame store written during read")
  `TCW_ASSERT_IMPL(a_scroll_dest, state_q == S_SCROLL && pend_q, int'(pend_addr_q) < LAST_LINE, "scroll copy beat outside upper lines")
  `TCW_ASSERT_ALWAYS(a_pos_range, int'(row_q) < tcw_pkg::ROWS && int'(col_q) < tcw_pkg::COLUMNS, "text position out of screen")

endmodule

`default_nettype wire

[rtl/core/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
